// ----- hw/rtl/joystick_deadzone_turntable_cmd_defines.svh -----
// Assertion macros for the joystick dead-zone turntable command block
`ifndef JOYSTICK_DEADZONE_TURNTABLE_CMD_DEFINES_SVH
`define JOYSTICK_DEADZONE_TURNTABLE_CMD_DEFINES_SVH

// same-cycle implication, disabled during reset
`define JDTC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jdtc assertion failed");

// next-cycle implication, disabled during reset
`define JDTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jdtc assertion failed");

`endif

// ----- hw/rtl/jdtc_pkg.sv -----
// Shared types and constants for the joystick dead-zone turntable command block
`timescale 1ns / 1ps

package jdtc_pkg;

  localparam int FIFO_DEPTH = 4;

  // configuration register indexes
  localparam logic REG_MANUAL_MODE = 1'b0;
  localparam logic REG_IDLE_LIMIT  = 1'b1;

  typedef enum logic [2:0] {
    DIR_LEFT  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_UP    = 3'd3,
    DIR_STOP  = 3'd4
  } dir_t;

  typedef struct packed {
    dir_t       direction;
    logic [6:0] speed;
    logic       last_of_run;
  } result_t;

  // up to two results written into the output queue in one cycle
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ----- hw/rtl/joystick_deadzone_turntable_cmd.sv -----
// Flow: an item is taken into the input register; while the result queue has room it is
// processed and its results are written into the queue, whose head is the output.
// Throughput: one item per cycle while the result queue has room; the output port moves one
// result per cycle when not stalled, so an item's two move commands leave one at a time (queue of FIFO_DEPTH).
// Reset: synchronous, active high; manual_mode 1, idle_limit 10, offsets and idle count
// zero, no stored offsets, input register and result queue empty.
`timescale 1ns / 1ps

module joystick_deadzone_turntable_cmd #(
  parameter int FIFO_DEPTH = jdtc_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [9:0] x_position,
  input  logic [9:0] y_position,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] direction,
  output logic [6:0] speed,
  output logic       last_of_run
);

  jdtc_pkg::push_t push;
  logic            room;

  jdtc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .x_position (x_position),
    .y_position (y_position),
    .room       (room),
    .push       (push)
  );

  jdtc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .direction   (direction),
    .speed       (speed),
    .last_of_run (last_of_run)
  );

endmodule

// ----- hw/rtl/jdtc_core.sv -----
// Input register, stick state and per-item command generation
`timescale 1ns / 1ps
`include "joystick_deadzone_turntable_cmd_defines.svh"

module jdtc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [9:0]        x_position,
  input  logic [9:0]        y_position,
  input  logic              room,
  output jdtc_pkg::push_t   push
);

  localparam logic [10:0] DZ_LOW  = 11'd400;
  localparam logic [10:0] DZ_HIGH = 11'd600;
  // floor(n*64/400) = (n*MulLo) >> 16, floor(n*64/423) = (n*MulHi) >> 20
  localparam logic [22:0] MulLo = 23'd10486;
  localparam logic [26:0] MulHi = 27'd158650;

  typedef struct packed {
    logic              valid;
    jdtc_pkg::result_t r;
  } axis_cmd_t;

  logic       manual_mode;
  logic [7:0] idle_limit;
  logic [9:0] prev_x_offset, prev_x_offset_next;
  logic [9:0] prev_y_offset, prev_y_offset_next;
  logic       prev_valid, prev_valid_next;
  logic [7:0] idle_ticks, idle_ticks_next;

  logic       iv;
  logic       i_cmd;
  logic [9:0] i_x;
  logic [9:0] i_y;

  logic       accept;
  logic       process;
  logic [9:0] xo, yo;
  axis_cmd_t  xc, yc;

  function automatic logic [9:0] axis_offset(input logic [9:0] pos);
    logic [10:0] p;
    p = {1'b0, pos};
    if (p < DZ_LOW) begin
      axis_offset = 10'(p - DZ_LOW);
    end else if (p > DZ_HIGH) begin
      axis_offset = 10'(p - DZ_HIGH);
    end else begin
      axis_offset = '0;
    end
  endfunction

  function automatic axis_cmd_t axis_cmd(input logic [9:0] off, input jdtc_pkg::dir_t dneg,
                                         input jdtc_pkg::dir_t dpos);
    logic [8:0]  mag_lo;
    logic [22:0] prod_lo;
    logic [26:0] prod_hi;
    logic [6:0]  spd;
    mag_lo  = 9'(-off);
    prod_lo = 23'(mag_lo) * MulLo;
    prod_hi = 27'(off[8:0]) * MulHi;
    axis_cmd = '0;
    if (off[9]) begin
      spd = prod_lo[22:16];
      axis_cmd.r.direction = dneg;
    end else begin
      spd = prod_hi[26:20];
      axis_cmd.r.direction = dpos;
    end
    axis_cmd.r.speed = spd;
    axis_cmd.valid   = (off != '0) && (spd != '0);
  endfunction

  assign in_stall = iv && !room;
  assign accept   = in_valid && !in_stall;
  assign process  = iv && room;

  assign xo = axis_offset(i_x);
  assign yo = axis_offset(i_y);
  assign xc = axis_cmd(xo, jdtc_pkg::DIR_LEFT, jdtc_pkg::DIR_RIGHT);
  assign yc = axis_cmd(yo, jdtc_pkg::DIR_DOWN, jdtc_pkg::DIR_UP);

  always_comb begin
    prev_x_offset_next = prev_x_offset;
    prev_y_offset_next = prev_y_offset;
    prev_valid_next    = prev_valid;
    idle_ticks_next    = idle_ticks;
    push               = '0;
    if (process) begin
      if (i_cmd) begin
        if (prev_valid && prev_x_offset == '0 && prev_y_offset == '0) begin
          if (idle_ticks > idle_limit) begin
            push.n                = 2'd1;
            push.r0.direction     = jdtc_pkg::DIR_STOP;
            push.r0.speed         = '0;
            push.r0.last_of_run   = 1'b1;
            prev_valid_next       = 1'b0;
            idle_ticks_next       = '0;
          end else if (idle_ticks != 8'hFF) begin
            idle_ticks_next = idle_ticks + 8'd1;
          end
        end
      end else if (manual_mode) begin
        if (!(prev_valid && xo == prev_x_offset && yo == prev_y_offset)) begin
          prev_x_offset_next = xo;
          prev_y_offset_next = yo;
          prev_valid_next    = 1'b1;
          if (xo != '0 || yo != '0) begin
            idle_ticks_next = '0;
            if (xc.valid && yc.valid) begin
              push.n              = 2'd2;
              push.r0             = xc.r;
              push.r1             = yc.r;
              push.r1.last_of_run = 1'b1;
            end else if (xc.valid) begin
              push.n              = 2'd1;
              push.r0             = xc.r;
              push.r0.last_of_run = 1'b1;
            end else if (yc.valid) begin
              push.n              = 2'd1;
              push.r0             = yc.r;
              push.r0.last_of_run = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_mode   <= 1'b1;
      idle_limit    <= 8'd10;
      prev_x_offset <= '0;
      prev_y_offset <= '0;
      prev_valid    <= 1'b0;
      idle_ticks    <= '0;
      iv            <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          jdtc_pkg::REG_MANUAL_MODE: manual_mode <= cfg_data[0];
          jdtc_pkg::REG_IDLE_LIMIT:  idle_limit  <= cfg_data;
          default: ;
        endcase
      end
      prev_x_offset <= prev_x_offset_next;
      prev_y_offset <= prev_y_offset_next;
      prev_valid    <= prev_valid_next;
      idle_ticks    <= idle_ticks_next;
      if (accept) begin
        iv <= 1'b1;
      end else if (process) begin
        iv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      i_cmd <= cmd;
      i_x   <= x_position;
      i_y   <= y_position;
    end
  end

  `JDTC_ASSERT_NEXT(a_stop_clears_valid, clk, rst,
                    (push.n != 2'd0 && push.r0.direction == jdtc_pkg::DIR_STOP),
                    (!prev_valid && idle_ticks == 8'd0))
  `JDTC_ASSERT_IMPL(a_pair_last, clk, rst, (push.n == 2'd2),
                    (!push.r0.last_of_run && push.r1.last_of_run &&
                     push.r0.direction != jdtc_pkg::DIR_STOP))

endmodule

// ----- hw/rtl/jdtc_fifo.sv -----
// Result queue: takes up to two results a cycle, hands out one per transfer
`timescale 1ns / 1ps
`include "joystick_deadzone_turntable_cmd_defines.svh"

module jdtc_fifo #(
  parameter int DEPTH = jdtc_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  jdtc_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      direction,
  output logic [6:0]      speed,
  output logic            last_of_run
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jdtc_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [PTR_W-1:0]  wr_ptr1, wr_ptr2;
  logic [CNT_W-1:0]  count;
  logic              pop;
  jdtc_pkg::result_t head;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr1   = ptr_inc(wr_ptr);
  assign wr_ptr2   = ptr_inc(wr_ptr1);
  assign room      = (count <= CNT_W'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rd_ptr];

  assign direction   = head.direction;
  assign speed       = head.speed;
  assign last_of_run = head.last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push.n)
        2'd1:    wr_ptr <= wr_ptr1;
        2'd2:    wr_ptr <= wr_ptr2;
        default: ;
      endcase
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CNT_W'(push.n) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  `JDTC_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, (count <= CNT_W'(DEPTH)))
  `JDTC_ASSERT_IMPL(a_push_has_room, clk, rst, (push.n != 2'd0), (count <= CNT_W'(DEPTH - 2)))

endmodule

// ----- bench/joystick_deadzone_turntable_cmd_tb.sv -----
// Testbench for joystick_deadzone_turntable_cmd: scoreboard, drivers, directed and random items
`timescale 1ns / 1ps

localparam int DZ_LOW     = 400;
localparam int DZ_HIGH    = 600;
localparam int AXIS_TOP   = 1023;
localparam int FULL_SPEED = 64;

class turntable_scoreboard;
  bit       manual_mode = 1'b1;
  bit [7:0] idle_limit  = 8'd10;
  bit [9:0] held_x;
  bit [9:0] held_y;
  bit       held_valid;
  bit [7:0] idle_count;
  jdtc_pkg::result_t expected_cmds[$];
  int       mismatches;
  int       moves_checked;
  int       stops_checked;

  function void write_reg(bit idx, bit [7:0] data);
    if (idx == jdtc_pkg::REG_MANUAL_MODE) manual_mode = data[0];
    else idle_limit = data;
  endfunction

  function int pending();
    return expected_cmds.size();
  endfunction

  function int dead_zone_offset(bit [9:0] pos);
    int p;
    p = pos;
    if (p < DZ_LOW) return p - DZ_LOW;
    if (p > DZ_HIGH) return p - DZ_HIGH;
    return 0;
  endfunction

  function void push_cmd(jdtc_pkg::dir_t dir, int spd);
    jdtc_pkg::result_t r;
    r.direction   = dir;
    r.speed       = spd[6:0];
    r.last_of_run = 1'b0;
    expected_cmds.push_back(r);
  endfunction

  function void axis_move(int off, jdtc_pkg::dir_t toward_low, jdtc_pkg::dir_t toward_high);
    int spd;
    if (off < 0) begin
      spd = (-off * FULL_SPEED) / DZ_LOW;
      if (spd != 0) push_cmd(toward_low, spd);
    end else if (off > 0) begin
      spd = (off * FULL_SPEED) / (AXIS_TOP - DZ_HIGH);
      if (spd != 0) push_cmd(toward_high, spd);
    end
  endfunction

  function void note_input(bit is_tick, bit [9:0] x, bit [9:0] y);
    int xo;
    int yo;
    int queued;
    queued = expected_cmds.size();
    if (is_tick) begin
      if (held_valid && held_x == 10'd0 && held_y == 10'd0) begin
        if (idle_count > idle_limit) begin
          push_cmd(jdtc_pkg::DIR_STOP, 0);
          held_valid = 1'b0;
          idle_count = 8'd0;
        end else if (idle_count != 8'hFF) begin
          idle_count++;
        end
      end
    end else if (manual_mode) begin
      xo = dead_zone_offset(x);
      yo = dead_zone_offset(y);
      if (!(held_valid && held_x == 10'(xo) && held_y == 10'(yo))) begin
        held_x     = 10'(xo);
        held_y     = 10'(yo);
        held_valid = 1'b1;
        if (xo != 0 || yo != 0) begin
          idle_count = 8'd0;
          axis_move(xo, jdtc_pkg::DIR_LEFT, jdtc_pkg::DIR_RIGHT);
          axis_move(yo, jdtc_pkg::DIR_DOWN, jdtc_pkg::DIR_UP);
        end
      end
    end
    if (expected_cmds.size() > queued)
      expected_cmds[expected_cmds.size() - 1].last_of_run = 1'b1;
  endfunction

  function void check_result(logic [2:0] dir, logic [6:0] spd, logic last);
    jdtc_pkg::result_t want;
    if (expected_cmds.size() == 0) begin
      $error("unexpected command: direction %0d speed %0d last_of_run %0d", dir, spd, last);
      mismatches++;
      return;
    end
    want = expected_cmds.pop_front();
    if (dir !== want.direction) begin
      $error("direction: expected %0d, actual %0d", want.direction, dir);
      mismatches++;
    end
    if (spd !== want.speed) begin
      $error("speed: expected %0d, actual %0d", want.speed, spd);
      mismatches++;
    end
    if (last !== want.last_of_run) begin
      $error("last_of_run: expected %0d, actual %0d", want.last_of_run, last);
      mismatches++;
    end
    if (want.direction == jdtc_pkg::DIR_STOP) stops_checked++;
    else moves_checked++;
  endfunction
endclass

module joystick_deadzone_turntable_cmd_tb;
  localparam int WATCHDOG_LIMIT = 1000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       cmd = 1'b0;
  logic [9:0] x_position = 10'd0;
  logic [9:0] y_position = 10'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] direction;
  logic [6:0] speed;
  logic       last_of_run;

  turntable_scoreboard sb = new;

  bit in_burst;
  bit out_burst;
  int samples_sent;
  int ticks_sent;
  int settings_run;
  int idle_cycles;

  joystick_deadzone_turntable_cmd dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .x_position  (x_position),
    .y_position  (y_position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .direction   (direction),
    .speed       (speed),
    .last_of_run (last_of_run)
  );

  always #2 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(direction, speed, last_of_run);
  end

  // receiver backpressure
  initial begin
    int hold;
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 17);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input bit is_tick, input bit [9:0] x, input bit [9:0] y);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    cmd        <= is_tick;
    x_position <= x;
    y_position <= y;
    do @(posedge clk); while (in_stall);
    sb.note_input(is_tick, x, y);
    if (is_tick) ticks_sent++;
    else samples_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input bit idx, input bit [7:0] data);
    @(negedge clk);
    sb.write_reg(idx, data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic bit [9:0] pick_position();
    bit [9:0] pos;
    case ($urandom_range(0, 9))
      0, 1: pos = 10'($urandom_range(0, DZ_LOW - 1));
      2, 3: pos = 10'($urandom_range(DZ_HIGH + 1, AXIS_TOP));
      4: pos = 10'($urandom_range(DZ_LOW, DZ_HIGH));
      5: begin
        case ($urandom_range(0, 5))
          0: pos = 10'd0;
          1: pos = 10'(DZ_LOW - 1);
          2: pos = 10'(DZ_LOW);
          3: pos = 10'(DZ_HIGH);
          4: pos = 10'(DZ_HIGH + 1);
          default: pos = 10'(AXIS_TOP);
        endcase
      end
      6: pos = 10'($urandom_range(DZ_LOW - 10, DZ_LOW - 4));
      7: pos = 10'($urandom_range(DZ_HIGH + 4, DZ_HIGH + 10));
      default: pos = 10'($urandom());
    endcase
    return pos;
  endfunction

  task automatic run_directed();
    write_reg(jdtc_pkg::REG_IDLE_LIMIT, 8'd0);
    send_item(1'b1, 10'd0, 10'd0);
    send_item(1'b0, 10'd500, 10'd500);
    send_item(1'b0, 10'd450, 10'd550);
    send_item(1'b1, 10'd1023, 10'd1023);
    send_item(1'b1, 10'd0, 10'd0);
    send_item(1'b1, 10'd0, 10'd0);
    send_item(1'b0, 10'd0, 10'd1023);
    send_item(1'b0, 10'd0, 10'd1023);
    send_item(1'b0, 10'd1023, 10'd0);
    send_item(1'b0, 10'd394, 10'd606);
    send_item(1'b1, 10'd0, 10'd0);
    send_item(1'b0, 10'd393, 10'd607);
    send_item(1'b0, 10'd399, 10'd601);
    send_item(1'b0, 10'd400, 10'd600);
    send_item(1'b0, 10'd300, 10'd500);
    send_item(1'b0, 10'd500, 10'd800);
    send_item(1'b1, 10'd0, 10'd0);
    send_item(1'b0, 10'd600, 10'd400);
    send_item(1'b1, 10'd0, 10'd0);
    send_item(1'b1, 10'd0, 10'd0);
    drain();
    write_reg(jdtc_pkg::REG_MANUAL_MODE, 8'd0);
    send_item(1'b0, 10'd0, 10'd0);
    send_item(1'b0, 10'd1023, 10'd1023);
    send_item(1'b1, 10'd0, 10'd0);
    settings_run += 2;
  endtask

  // stick moves, a return to center, then a run of idle ticks; some noise in between
  task automatic run_phase(input bit mode, input bit [7:0] limit, input int budget,
                           input int long_run);
    int start;
    int moves;
    int run_len;
    bit [9:0] x;
    bit [9:0] y;
    drain();
    write_reg(jdtc_pkg::REG_MANUAL_MODE, {7'd0, mode});
    write_reg(jdtc_pkg::REG_IDLE_LIMIT, limit);
    settings_run++;
    start = samples_sent + ticks_sent;
    while (samples_sent + ticks_sent - start < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        moves = $urandom_range(1, 5);
        repeat (moves) begin
          x = pick_position();
          y = pick_position();
          send_item(1'b0, x, y);
          if ($urandom_range(0, 3) == 0) send_item(1'b0, x, y);
        end
        send_item(1'b0, 10'($urandom_range(DZ_LOW, DZ_HIGH)),
                  10'($urandom_range(DZ_LOW, DZ_HIGH)));
        if (long_run > 0) run_len = long_run;
        else run_len = $urandom_range(0, (limit > 30) ? 34 : limit + 4);
        long_run = 0;
        repeat (run_len) send_item(1'b1, 10'($urandom()), 10'($urandom()));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(0, 1)), 10'($urandom()), 10'($urandom()));
      end
      if ($urandom_range(0, 29) == 0) drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_phase(1'b1, 8'd10, 300, 0);
    run_phase(1'b1, 8'd0, 230, 0);
    run_phase(1'b1, 8'd255, 320, 270);
    run_phase(1'b0, 8'd5, 80, 0);
    run_phase(1'b1, 8'd1, 250, 0);
    run_phase(1'b1, 8'd37, 250, 0);

    drain();
    repeat (16) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected commands never arrived", sb.pending());
      sb.mismatches++;
    end

    $display("Sent %0d stick samples and %0d idle ticks over %0d register settings",
             samples_sent, ticks_sent, settings_run);
    $display("Checked %0d move commands and %0d stop commands", sb.moves_checked,
             sb.stops_checked);
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
